[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CPA_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check an implication on every clock edge, reset included.
`define CPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants and types of the cell pedestal averager.
// ----------------------------------------------------------------------------
package cpa_pkg;
   localparam int Channels     = 16;
   localparam int Cells        = 4096;
   localparam int MaxReadDepth = 4096;

   localparam int CHAN_W  = 4;
   localparam int CELL_W  = 12;
   localparam int POS_W   = 12;
   localparam int ADC_W   = 16;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = 32;
   localparam int AVG_W   = 24;
   localparam int CIDX_W  = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int CHI_W   = (Channels > 1) ? $clog2(Channels) : 1;
   localparam int ADDR_W  = CHI_W + CIDX_W;
   localparam int DEPTH   = Channels * Cells;
   localparam int SKIP_RESET = 3;
   localparam int CLR_W   = ADDR_W + 1;

   // Dividend of the mean: sum*256 + count/2, fits in 57 bits.
   localparam int DVD_W   = SUM_W + 9;

   typedef enum logic {
      ACT_ACCUMULATE = 1'b0,
      ACT_READ       = 1'b1
   } action_type;

   localparam logic [1:0] CSR_ADDR_SKIP = 2'd0;

   typedef struct packed {
      logic               is_read;
      logic               chan_bad;
      logic [ADDR_W-1:0]  addr;
      logic [ADC_W-1:0]   adc;
   } cmd_type;

   typedef struct packed {
      logic [AVG_W-1:0]  average_value;
      logic              cell_empty;
      logic [CNT_W-1:0]  sample_count;
      logic              saturated;
   } rsp_type;
endpackage

[rtl/cpa_if.sv]
// ----------------------------------------------------------------------------
// cpa_req_if / cpa_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface cpa_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [3:0]  channel;
   logic [11:0] stop_cell;
   logic [11:0] sample_position;
   logic [15:0] adc_value;
   modport source (output valid, action, channel, stop_cell, sample_position, adc_value,
                   input ready);
   modport sink (input valid, action, channel, stop_cell, sample_position, adc_value,
                 output ready);
endinterface

interface cpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] average_value;
   logic        cell_empty;
   logic [31:0] sample_count;
   logic        saturated;
   modport source (output valid, average_value, cell_empty, sample_count, saturated,
                   input ready);
   modport sink (input valid, average_value, cell_empty, sample_count, saturated,
                 output ready);
endinterface

[rtl/cpa_front.sv]
// ----------------------------------------------------------------------------
// cpa_front
// Accepts requests, filters dropped samples and forms the table address.
// ----------------------------------------------------------------------------
module cpa_front (
   cpa_req_if.sink                      req,
   input  logic [cpa_pkg::POS_W-1:0]    skip_cells,
   input  logic                         q_full,
   output logic                         q_push,
   output cpa_pkg::cmd_type             q_cmd
);
   logic                         is_read;
   logic                         chan_bad;
   logic                         keep;
   logic [cpa_pkg::CELL_W:0]     cell_sum;
   logic [cpa_pkg::CIDX_W-1:0]   cidx;
   logic [cpa_pkg::CHI_W-1:0]    chi;

   assign req.ready = !q_full;
   assign is_read   = (req.action == cpa_pkg::ACT_READ);
   assign chan_bad  = ({1'b0, req.channel} >= (cpa_pkg::CHAN_W+1)'(cpa_pkg::Channels));
   assign cell_sum  = is_read ? {1'b0, req.sample_position}
                              : {1'b0, req.stop_cell} + {1'b0, req.sample_position};

   // Reduce the cell number modulo the cell count (a power of two).
   always_comb begin
      cidx = cell_sum[cpa_pkg::CIDX_W-1:0];
      chi  = cpa_pkg::CHI_W'(req.channel);
   end

   // Drop samples of bad channels, skipped or too deep positions.
   assign keep = is_read ||
                 (!chan_bad &&
                  ({1'b0, req.sample_position} < (cpa_pkg::POS_W+1)'(cpa_pkg::MaxReadDepth)) &&
                  (req.sample_position >= skip_cells));

   assign q_push        = req.valid && req.ready && keep;
   assign q_cmd.is_read = is_read;
   assign q_cmd.chan_bad = chan_bad;
   assign q_cmd.addr    = {chi, cidx};
   assign q_cmd.adc     = req.adc_value;
endmodule

[rtl/cpa_queue.sv]
// ----------------------------------------------------------------------------
// cpa_queue
// Small command queue between the front and the table engine.
// ----------------------------------------------------------------------------
module cpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cpa_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cpa_pkg::cmd_type  head
);
   cpa_pkg::cmd_type  slot_ff [4];
   logic [1:0]        wr_ff, rd_ff, wr_in, rd_in;
   logic [2:0]        cnt_ff, cnt_in;

   assign full      = (cnt_ff == 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   // Advance pointers and store the pushed command.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end
endmodule

[rtl/cpa_divider.sv]
// ----------------------------------------------------------------------------
// cpa_divider
// Radix-2 restoring divider for the cell mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cpa_pkg::DVD_W-1:0]    dividend,
   input  logic [cpa_pkg::CNT_W-1:0]    divisor,
   output logic                         done,
   output logic [cpa_pkg::AVG_W-1:0]    quotient
);
   localparam int STEP_W = $clog2(cpa_pkg::DVD_W + 1);

   logic [cpa_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [cpa_pkg::CNT_W:0]    rem_ff, rem_in;
   logic [cpa_pkg::CNT_W-1:0]  dsr_ff;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [cpa_pkg::CNT_W+1:0]  trial;

   // Load the operands on start, else one shift-subtract step while busy.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(cpa_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[cpa_pkg::DVD_W-1]} - {2'b0, dsr_ff};
         if (!trial[cpa_pkg::CNT_W+1]) begin
            rem_in = trial[cpa_pkg::CNT_W:0];
            quo_in = {quo_ff[cpa_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[cpa_pkg::CNT_W-1:0], quo_ff[cpa_pkg::DVD_W-1]};
            quo_in = {quo_ff[cpa_pkg::DVD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   // Clamp the quotient to the Q16.8 range.
   assign done     = done_ff;
   assign quotient = (|quo_ff[cpa_pkg::DVD_W-1:cpa_pkg::AVG_W]) ? '1
                                                              : quo_ff[cpa_pkg::AVG_W-1:0];
endmodule

[rtl/cpa_engine.sv]
// ----------------------------------------------------------------------------
// cpa_engine
// Table engine: clears the table after reset, applies accumulates and
// answers reads, through the divider for cells that hold samples.
// ----------------------------------------------------------------------------
module cpa_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cpa_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              clearing,
   cpa_rsp_if.source         rsp
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_DIVIDE, ST_SEND
   } state_type;

   localparam int ENTRY_W = cpa_pkg::SUM_W + cpa_pkg::CNT_W + 1;

   logic [ENTRY_W-1:0]             mem [cpa_pkg::DEPTH];
   logic [ENTRY_W-1:0]             rd_data_ff;

   state_type                      state_ff;
   logic [cpa_pkg::CLR_W-1:0]      clr_ff;
   cpa_pkg::cmd_type               cmd_ff;
   cpa_pkg::rsp_type               out_ff;
   logic                           out_valid_ff;

   logic                           wr_en;
   logic [cpa_pkg::ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]             wr_data;
   logic                           rd_en;

   logic [cpa_pkg::SUM_W-1:0]      old_sum;
   logic [cpa_pkg::CNT_W-1:0]      old_cnt;
   logic                           old_sat;
   logic [cpa_pkg::SUM_W:0]        new_sum_w;
   logic [cpa_pkg::SUM_W-1:0]      new_sum;
   logic [cpa_pkg::CNT_W-1:0]      new_cnt;
   logic                           new_sat;

   logic                           div_start, div_done;
   logic [cpa_pkg::DVD_W-1:0]      dividend;
   logic [cpa_pkg::AVG_W-1:0]      quotient;

   assign {old_sum, old_cnt, old_sat} = rd_data_ff;

   // Saturating update of one table entry.
   always_comb begin
      new_sum_w = {1'b0, old_sum} + {{(cpa_pkg::SUM_W+1-cpa_pkg::ADC_W){1'b0}}, cmd_ff.adc};
      new_sum   = new_sum_w[cpa_pkg::SUM_W] ? '1 : new_sum_w[cpa_pkg::SUM_W-1:0];
      new_cnt   = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
      new_sat   = old_sat || new_sum_w[cpa_pkg::SUM_W] || (&old_cnt);
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && !out_valid_ff;
   assign rd_en     = q_pop && !(q_cmd.is_read && q_cmd.chan_bad);
   assign wr_en     = clearing || (state_ff == ST_UPDATE);
   assign wr_addr   = clearing ? clr_ff[cpa_pkg::ADDR_W-1:0] : cmd_ff.addr;
   assign wr_data   = clearing ? '0 : {new_sum, new_cnt, new_sat};
   assign div_start = (state_ff == ST_READ) && (old_cnt != '0);
   assign dividend  = {1'b0, old_sum, 8'd0} + {{(cpa_pkg::DVD_W-cpa_pkg::CNT_W+1){1'b0}},
                                                old_cnt[cpa_pkg::CNT_W-1:1]};

   // Single-port table memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[q_cmd.addr];
      end
   end

   cpa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (old_cnt),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == cpa_pkg::CLR_W'(cpa_pkg::DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff <= q_cmd;
                  if (!q_cmd.is_read) begin
                     state_ff <= ST_UPDATE;
                  end else if (q_cmd.chan_bad) begin
                     out_ff       <= '{average_value: '0, cell_empty: 1'b1,
                                       sample_count: '0, saturated: 1'b0};
                     out_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_IDLE;
            end
            ST_READ: begin
               out_ff.cell_empty   <= (old_cnt == '0);
               out_ff.sample_count <= old_cnt;
               out_ff.saturated    <= old_sat;
               out_ff.average_value <= '0;
               state_ff <= (old_cnt == '0) ? ST_SEND : ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  out_ff.average_value <= quotient;
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               out_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.average_value = out_ff.average_value;
   assign rsp.cell_empty    = out_ff.cell_empty;
   assign rsp.sample_count  = out_ff.sample_count;
   assign rsp.saturated     = out_ff.saturated;
endmodule

[rtl/cell_pedestal_averager.sv]
// ----------------------------------------------------------------------------
// cell_pedestal_averager
// Per-channel, per-cell pedestal sum/count table with mean readout.
// ----------------------------------------------------------------------------
// Usage:
//   req carries accumulate or read transactions; rsp returns one transaction
//   for each read and none for an accumulate. csr writes skip_cells (addr 0).
//   After reset the block sweeps the whole table, one entry per cycle
//   (Channels*Cells = 65536 entries), with req.ready low; skip_cells is 3.
//   A kept accumulate passes the table engine as a read, then a modify
//   and write on the single-port memory; dropped samples are taken and
//   discarded in the front. A read of a hit cell goes through the queue,
//   table read, 57-step divider with done flag and response register;
//   an empty cell skips the divider, a bad channel also the table read.
//   A four-entry queue separates the front from the engine, so requests are
//   taken while the engine works until the queue fills. A stalled rsp holds
//   its transaction and the engine waits before the next table access.
// ----------------------------------------------------------------------------
module cell_pedestal_averager (
   input  logic         clock,
   input  logic         reset,
   cpa_req_if.sink      req,
   cpa_rsp_if.source    rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [cpa_pkg::POS_W-1:0]  skip_ff;
   logic                       q_full, q_push, q_pop, q_valid, clearing;
   cpa_pkg::cmd_type           push_cmd, head_cmd;
   cpa_req_if                  req_gated ();

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == cpa_pkg::CSR_ADDR_SKIP) ? {20'd0, skip_ff} : 32'd0;

   // Register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= cpa_pkg::POS_W'(cpa_pkg::SKIP_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == cpa_pkg::CSR_ADDR_SKIP) begin
         skip_ff <= csr_pwdata[cpa_pkg::POS_W-1:0];
      end
   end

   // Hold requests off during the clearing sweep.
   assign req_gated.valid           = req.valid && !clearing;
   assign req_gated.action          = req.action;
   assign req_gated.channel         = req.channel;
   assign req_gated.stop_cell       = req.stop_cell;
   assign req_gated.sample_position = req.sample_position;
   assign req_gated.adc_value       = req.adc_value;
   assign req.ready                 = req_gated.ready && !clearing;

   cpa_front u_front (
      .req (req_gated), .skip_cells (skip_ff),
      .q_full (q_full), .q_push (q_push), .q_cmd (push_cmd)
   );

   cpa_queue u_queue (
      .clock (clock), .reset (reset), .push (q_push), .push_cmd (push_cmd),
      .full (q_full), .pop (q_pop), .not_empty (q_valid), .head (head_cmd)
   );

   cpa_engine u_engine (
      .clock (clock), .reset (reset), .q_valid (q_valid), .q_cmd (head_cmd),
      .q_pop (q_pop), .clearing (clearing), .rsp (rsp)
   );
endmodule

[rtl/cpa_checker.sv]
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the cell pedestal averager.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic         rsp_cell_empty,
   input logic [23:0]  rsp_average_value,
   input logic [31:0]  rsp_sample_count,
   input logic         csr_pready
);
   `CPA_ASSERT_ALWAYS(a_pready_high, clock, csr_pready, "pready low")
   `CPA_ASSERT_IMPL(a_empty_zero, clock, reset,
      rsp_valid && rsp_cell_empty |-> rsp_average_value == 24'd0, "empty cell nonzero mean")
   `CPA_ASSERT_IMPL(a_empty_count, clock, reset,
      rsp_valid |-> (rsp_cell_empty == (rsp_sample_count == 32'd0)), "empty flag mismatch")
   `CPA_ASSERT_IMPL(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_count), "response dropped")
   `CPA_ASSERT_ALWAYS(a_reset_quiet, clock,
      $past(reset) |-> !req_ready && !rsp_valid, "active right after reset")
endmodule

bind cell_pedestal_averager cpa_checker u_cpa_checker (
   .clock (clock), .reset (reset),
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_cell_empty (rsp.cell_empty), .rsp_average_value (rsp.average_value),
   .rsp_sample_count (rsp.sample_count), .csr_pready (csr_pready)
);
